@@ design/bsti_pkg.sv @@
package bsti_pkg;

  localparam int RATIO_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int TERM_W    = 64;
  localparam int SUM_W     = 64;
  localparam int OUT_W     = 32;
  localparam int NUM_SUMS  = 4;

  typedef logic [1:0] sum_idx_t;

  localparam sum_idx_t IDX_TOTAL    = 2'd0;
  localparam sum_idx_t IDX_INSPIRAL = 2'd1;
  localparam sum_idx_t IDX_MERGER   = 2'd2;
  localparam sum_idx_t IDX_RINGDOWN = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV1_GO,
    S_DIV1,
    S_SQR,
    S_DIV2_GO,
    S_DIV2,
    S_MUL_GO,
    S_MUL,
    S_ACC,
    S_FIN,
    S_ROOT_GO,
    S_ROOT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_sel;
    logic     ratio_cap;
    logic     sq_cap;
    logic     term_cap;
    logic     mul_start;
    logic     acc;
    logic     fin;
    logic     root_start;
    sum_idx_t root_idx;
    logic     root_cap;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
    logic root_busy;
    logic first;
    logic last;
  } status_t;

endpackage

@@ design/bsti_in_if.sv @@
interface bsti_in_if #(
  parameter int FREQ_WIDTH   = 32,
  parameter int STRAIN_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [FREQ_WIDTH-1:0]   freq;
  logic [STRAIN_WIDTH-1:0] signal_strain;
  logic [STRAIN_WIDTH-1:0] noise_strain;
  logic [FREQ_WIDTH-1:0]   merger_freq;
  logic [FREQ_WIDTH-1:0]   peak_freq;
  logic                    last;

  modport source(output valid, freq, signal_strain, noise_strain, merger_freq, peak_freq,
                 last, input ready);
  modport sink(input valid, freq, signal_strain, noise_strain, merger_freq, peak_freq,
               last, output ready);
endinterface

@@ design/bsti_out_if.sv @@
interface bsti_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] snr_total;
  logic [31:0] snr_inspiral;
  logic [31:0] snr_merger;
  logic [31:0] snr_ringdown;

  modport source(output valid, snr_total, snr_inspiral, snr_merger, snr_ringdown,
                 input ready);
  modport sink(input valid, snr_total, snr_inspiral, snr_merger, snr_ringdown,
               output ready);
endinterface

@@ design/bsti_div.sv @@
module bsti_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], fits};
      rem  <= fits ? DEN_W'(trial - {1'b0, dvs}) : trial[DEN_W-1:0];
    end
  end
endmodule

@@ design/bsti_sqrt.sv @@
module bsti_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bsti_pkg::SUM_W-1:0] x,
  output logic                       busy,
  output logic [bsti_pkg::OUT_W-1:0] root
);
  localparam int XW = bsti_pkg::SUM_W;
  localparam int RW = bsti_pkg::OUT_W;

  logic [$clog2(RW+1)-1:0] cnt;
  logic [XW-1:0]           xs;
  logic [RW+1:0]           rem;
  logic [RW+3:0]           cur;
  logic [RW+3:0]           trial;
  logic                    fits;

  // two radicand bits per cycle, one root bit per cycle
  assign cur   = {rem, xs[XW-1:XW-2]};
  assign trial = (RW+4)'({root, 2'b01});
  assign fits  = cur >= trial;
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= ($clog2(RW+1))'(RW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= {xs[XW-3:0], 2'b00};
      rem  <= fits ? (RW+2)'(cur - trial) : cur[RW+1:0];
      root <= {root[RW-2:0], fits};
    end
  end
endmodule

@@ design/bsti_ctrl.sv @@
module bsti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bsti_pkg::status_t status,
  output bsti_pkg::cmd_t    cmd
);
  bsti_pkg::state_t   state, state_next;
  bsti_pkg::sum_idx_t idx;
  logic               out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsti_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= bsti_pkg::IDX_TOTAL;
    end else if (state == bsti_pkg::S_FIN) begin
      idx <= bsti_pkg::IDX_TOTAL;
    end else if (state == bsti_pkg::S_ROOT && !status.root_busy) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bsti_pkg::S_IDLE:    if (in_valid) state_next = bsti_pkg::S_DIV1_GO;
      bsti_pkg::S_DIV1_GO: state_next = bsti_pkg::S_DIV1;
      bsti_pkg::S_DIV1:    if (!status.div_busy) state_next = bsti_pkg::S_SQR;
      bsti_pkg::S_SQR:     state_next = bsti_pkg::S_DIV2_GO;
      bsti_pkg::S_DIV2_GO: state_next = bsti_pkg::S_DIV2;
      bsti_pkg::S_DIV2: begin
        if (!status.div_busy) begin
          state_next = status.first ? bsti_pkg::S_FIN : bsti_pkg::S_MUL_GO;
        end
      end
      bsti_pkg::S_MUL_GO:  state_next = bsti_pkg::S_MUL;
      bsti_pkg::S_MUL:     if (!status.mul_busy) state_next = bsti_pkg::S_ACC;
      bsti_pkg::S_ACC:     state_next = bsti_pkg::S_FIN;
      bsti_pkg::S_FIN:     state_next = status.last ? bsti_pkg::S_ROOT_GO : bsti_pkg::S_IDLE;
      bsti_pkg::S_ROOT_GO: state_next = bsti_pkg::S_ROOT;
      bsti_pkg::S_ROOT: begin
        if (!status.root_busy) begin
          state_next = (idx == bsti_pkg::IDX_RINGDOWN) ? bsti_pkg::S_OUT
                                                        : bsti_pkg::S_ROOT_GO;
        end
      end
      bsti_pkg::S_OUT:     if (out_free) state_next = bsti_pkg::S_IDLE;
      default:             state_next = bsti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.root_idx = idx;
    in_ready     = 1'b0;
    case (state)
      bsti_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bsti_pkg::S_DIV1_GO: cmd.div_start = 1'b1;
      bsti_pkg::S_DIV1:    cmd.ratio_cap = !status.div_busy;
      bsti_pkg::S_SQR:     cmd.sq_cap = 1'b1;
      bsti_pkg::S_DIV2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      bsti_pkg::S_DIV2:    cmd.term_cap = !status.div_busy;
      bsti_pkg::S_MUL_GO:  cmd.mul_start = 1'b1;
      bsti_pkg::S_ACC:     cmd.acc = 1'b1;
      bsti_pkg::S_FIN:     cmd.fin = 1'b1;
      bsti_pkg::S_ROOT_GO: cmd.root_start = 1'b1;
      bsti_pkg::S_ROOT:    cmd.root_cap = !status.root_busy;
      bsti_pkg::S_OUT:     cmd.out_load = out_free;
      default:             cmd = '0;
    endcase
  end
endmodule

@@ design/bsti_datapath.sv @@
module bsti_datapath #(
  parameter int FREQ_WIDTH   = 32,
  parameter int STRAIN_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsti_pkg::cmd_t             cmd,
  output bsti_pkg::status_t          status,
  input  logic [FREQ_WIDTH-1:0]      freq,
  input  logic [STRAIN_WIDTH-1:0]    signal_strain,
  input  logic [STRAIN_WIDTH-1:0]    noise_strain,
  input  logic [FREQ_WIDTH-1:0]      merger_freq,
  input  logic [FREQ_WIDTH-1:0]      peak_freq,
  input  logic                       last,
  output logic [bsti_pkg::OUT_W-1:0] snr_total,
  output logic [bsti_pkg::OUT_W-1:0] snr_inspiral,
  output logic [bsti_pkg::OUT_W-1:0] snr_merger,
  output logic [bsti_pkg::OUT_W-1:0] snr_ringdown
);
  localparam int TW    = bsti_pkg::TERM_W;
  localparam int SW    = bsti_pkg::SUM_W;
  localparam int RTW   = bsti_pkg::RATIO_W;
  localparam int DEN_W = (FREQ_WIDTH > STRAIN_WIDTH) ? FREQ_WIDTH : STRAIN_WIDTH;
  localparam int MCW   = $clog2(FREQ_WIDTH + 1);

  logic [FREQ_WIDTH-1:0]   f, m, p, prev_freq;
  logic [STRAIN_WIDTH-1:0] s, n;
  logic                    last_r, first;
  logic [RTW-1:0]          ratio;
  logic [TW-1:0]           sq, term, prev_term, half;
  logic [SW-1:0]           sums [bsti_pkg::NUM_SUMS];
  logic [bsti_pkg::OUT_W-1:0] roots [bsti_pkg::NUM_SUMS];

  logic [TW-1:0]    div_num, div_quot;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic [bsti_pkg::OUT_W-1:0] root;
  logic             root_busy;

  logic [FREQ_WIDTH-1:0] diff;
  logic                  down;
  bsti_pkg::sum_idx_t    band;
  logic [FREQ_WIDTH:0]   twice_mid;

  logic [SW-1:0]  macc;
  logic [MCW-1:0] mcnt;
  logic [SW:0]    madd;
  logic           msat;

  assign div_num = cmd.div_sel ? sq : TW'({s, {bsti_pkg::FRAC_BITS{1'b0}}});
  assign div_den = cmd.div_sel ? DEN_W'(f) : DEN_W'(n);

  bsti_div #(.NUM_W(TW), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quot(div_quot)
  );

  bsti_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.root_start), .x(sums[cmd.root_idx]),
    .busy(root_busy), .root(root)
  );

  assign status = '{div_busy: div_busy, mul_busy: mcnt != '0, root_busy: root_busy,
                    first: first, last: last_r};

  assign twice_mid = {1'b0, f} + {1'b0, prev_freq};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f      <= freq;
      s      <= signal_strain;
      n      <= noise_strain;
      m      <= merger_freq;
      p      <= peak_freq;
      last_r <= last;
    end
    if (cmd.ratio_cap) begin
      ratio <= (n == '0 || div_quot[TW-1:RTW] != '0) ? '1 : div_quot[RTW-1:0];
    end
    if (cmd.sq_cap) begin
      sq <= ratio * ratio;
    end
    if (cmd.term_cap) begin
      term <= (f == '0) ? '1 : div_quot;
    end
    if (cmd.mul_start) begin
      half <= TW'(({1'b0, term} + {1'b0, prev_term}) >> 1);
      down <= f < prev_freq;
      if (twice_mid <= {m, 1'b0}) begin
        band <= bsti_pkg::IDX_INSPIRAL;
      end else if (twice_mid >= {p, 1'b0}) begin
        band <= bsti_pkg::IDX_RINGDOWN;
      end else begin
        band <= bsti_pkg::IDX_MERGER;
      end
    end
    if (cmd.root_cap) begin
      roots[cmd.root_idx] <= root;
    end
    if (cmd.out_load) begin
      snr_total    <= roots[bsti_pkg::IDX_TOTAL];
      snr_inspiral <= roots[bsti_pkg::IDX_INSPIRAL];
      snr_merger   <= roots[bsti_pkg::IDX_MERGER];
      snr_ringdown <= roots[bsti_pkg::IDX_RINGDOWN];
    end
  end

  // saturating shift-add multiply, diff msb first; saturation is sticky
  assign madd = {1'b0, macc[SW-2:0], 1'b0} + {1'b0, diff[FREQ_WIDTH-1] ? half : '0};
  assign msat = macc[SW-1] || madd[SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mul_start) begin
      mcnt <= MCW'(FREQ_WIDTH);
    end else if (mcnt != '0) begin
      mcnt <= mcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      macc <= '0;
      diff <= (f < prev_freq) ? prev_freq - f : f - prev_freq;
    end else if (mcnt != '0) begin
      macc <= msat ? '1 : madd[SW-1:0];
      diff <= diff << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first     <= 1'b1;
      prev_freq <= '0;
      prev_term <= '0;
      for (int i = 0; i < bsti_pkg::NUM_SUMS; i++) sums[i] <= '0;
    end else begin
      if (cmd.acc) begin
        for (int i = 0; i < bsti_pkg::NUM_SUMS; i++) begin
          if (i == 0 || bsti_pkg::sum_idx_t'(i) == band) begin
            if (down) begin
              sums[i] <= (sums[i] > macc) ? sums[i] - macc : '0;
            end else begin
              sums[i] <= ({1'b0, sums[i]} + {1'b0, macc} > {1'b0, {SW{1'b1}}})
                         ? '1 : sums[i] + macc;
            end
          end
        end
      end
      if (cmd.fin) begin
        prev_freq <= f;
        prev_term <= term;
        first     <= 1'b0;
      end
      if (cmd.out_load) begin
        first <= 1'b1;
        for (int i = 0; i < bsti_pkg::NUM_SUMS; i++) sums[i] <= '0;
      end
    end
  end
endmodule

@@ design/banded_snr_trapezoid_integrator.sv @@
// each sample is divided, squared and divided again; one that is not the first of
// a run then multiplies and accumulates; a last sample adds four roots and the output load
// the shared restoring divider (run twice) and the serial root unit set the latency
// one sample in work at a time, the next transfer only after it ends;
// a finished result waits in the output register
// rst (synchronous) clears the sums, the control state and starts a new run
module banded_snr_trapezoid_integrator #(
  parameter int FREQ_WIDTH   = 32,
  parameter int STRAIN_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  bsti_in_if.sink           din,
  bsti_out_if.source        dout
);
  bsti_pkg::cmd_t    cmd;
  bsti_pkg::status_t status;

  bsti_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(din.valid), .in_ready(din.ready),
    .out_valid(dout.valid), .out_ready(dout.ready), .status(status), .cmd(cmd)
  );

  bsti_datapath #(.FREQ_WIDTH(FREQ_WIDTH), .STRAIN_WIDTH(STRAIN_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .freq(din.freq), .signal_strain(din.signal_strain), .noise_strain(din.noise_strain),
    .merger_freq(din.merger_freq), .peak_freq(din.peak_freq), .last(din.last),
    .snr_total(dout.snr_total), .snr_inspiral(dout.snr_inspiral),
    .snr_merger(dout.snr_merger), .snr_ringdown(dout.snr_ringdown)
  );
endmodule

@@ design/bsti_checker.sv @@
module bsti_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // a result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one sample in work at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // no result can appear in the cycle right after an input transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without computation time");
endmodule

bind banded_snr_trapezoid_integrator bsti_checker u_bsti_checker (
  .clk(clk), .rst(rst), .in_valid(din.valid), .in_ready(din.ready),
  .out_valid(dout.valid), .out_ready(dout.ready)
);
